// ----- rtl/cdb_pkg.sv -----
// package for the character display buffer: field widths, command codes,
// sequencer states and the default screen geometry; used by cdb_if and char_display_buffer_cursor
`default_nettype none

package cdb_pkg;

  localparam int COLUMNS_DEF = 16;
  localparam int ROWS        = 2;

  localparam int CMD_W      = 4;
  localparam int CHAR_W     = 8;
  localparam int TCOL_W     = 5;
  localparam int TROW_W     = 2;
  localparam int RIDX_W     = 5;
  localparam int OUT_COL_W  = 4;

  localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE      = 4'd0,
    CMD_LEFT       = 4'd1,
    CMD_RIGHT      = 4'd2,
    CMD_UP         = 4'd3,
    CMD_DOWN       = 4'd4,
    CMD_CLEAR      = 4'd5,
    CMD_CLEAR_EOL  = 4'd6,
    CMD_SET_CURSOR = 4'd7,
    CMD_READ_CELL  = 4'd8
  } cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SWEEP,
    S_READ,
    S_RESULT
  } state_t;

endpackage

`default_nettype wire

// ----- rtl/cdb_if.sv -----
// valid/ready channel interfaces for display commands and their results
// depends on cdb_pkg for field widths
`default_nettype none

interface cdb_in_if;
  import cdb_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [CHAR_W-1:0] char_code;
  logic [TCOL_W-1:0] target_column;
  logic [TROW_W-1:0] target_row;
  logic [RIDX_W-1:0] read_index;

  modport source (output valid, command, char_code, target_column, target_row,
                  read_index, input ready);
  modport sink   (input valid, command, char_code, target_column, target_row,
                  read_index, output ready);
endinterface

interface cdb_out_if;
  import cdb_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [OUT_COL_W-1:0] cursor_column;
  logic                 cursor_row;
  logic [CHAR_W-1:0]    cell_char;
  logic                 position_taken;

  modport source (output valid, cursor_column, cursor_row, cell_char, position_taken,
                  input ready);
  modport sink   (input valid, cursor_column, cursor_row, cell_char, position_taken,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/cdb_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module cdb_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(Depth)-1:0] wr_addr,
  input  wire logic [Width-1:0]         wr_data,
  input  wire logic [$clog2(Depth)-1:0] rd_addr,
  output logic      [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ----- rtl/char_display_buffer_cursor.sv -----
// two-row character display buffer with cursor: sequencer, cursor, cell ram
// depends on cdb_pkg, cdb_if (cdb_in_if, cdb_out_if) and cdb_ram
`default_nettype none

// One command is taken at a time; in_ch.ready is high only while the sequencer
// is idle, and a finished result sits in an output register so the next command
// can be taken while the result still waits. Cursor moves, write and set_cursor
// go straight from idle to the result step; read_cell has a read step for
// the registered ram read. Clear walks every one of the 2*Columns cells through
// the single ram write port, one cell per cycle; clear-to-end-of-line walks
// from the cursor cell to its row end. After reset cells read as spaces at once:
// per-cell valid bits stand in for the reset value, so there is no clearing pass.

module char_display_buffer_cursor #(
  parameter int Columns = cdb_pkg::COLUMNS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  cdb_in_if.sink     in_ch,
  cdb_out_if.source  out_ch
);
  import cdb_pkg::*;

  localparam int Cells = ROWS * Columns;
  localparam int AW    = $clog2(Cells);
  localparam int CW    = $clog2(Columns);

  state_t state_r, state_nxt;

  logic [CW-1:0]     cursor_col_r, cursor_col_nxt;
  logic              cursor_row_r, cursor_row_nxt;
  logic [AW-1:0]     sweep_addr_r, sweep_addr_nxt;
  logic [AW-1:0]     sweep_last_r, sweep_last_nxt;
  logic [AW-1:0]     rd_addr_r, rd_addr_nxt;
  logic              rd_ok_r, rd_ok_nxt;
  logic [CHAR_W-1:0] cell_r, cell_nxt;
  logic              taken_r, taken_nxt;
  logic [Cells-1:0]  vld_r;

  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_COL_W-1:0] out_col_r, out_col_nxt;
  logic                 out_row_r, out_row_nxt;
  logic [CHAR_W-1:0]    out_cell_r, out_cell_nxt;
  logic                 out_taken_r, out_taken_nxt;

  logic              in_acc;
  logic              out_free;
  cmd_t              cmd;
  logic [AW-1:0]     cur_addr;
  logic [AW-1:0]     row_end;
  logic [AW-1:0]     ridx_addr;
  logic              ram_we;
  logic [AW-1:0]     ram_wa;
  logic [CHAR_W-1:0] ram_wd;
  logic [CHAR_W-1:0] ram_rd;

  assign in_acc    = in_ch.valid && in_ch.ready;
  assign out_free  = !out_valid_r || out_ch.ready;
  assign cmd       = cmd_t'(in_ch.command);
  assign cur_addr  = (cursor_row_r ? AW'(Columns) : '0) + AW'(cursor_col_r);
  assign row_end   = cursor_row_r ? AW'(Cells - 1) : AW'(Columns - 1);
  assign ridx_addr = AW'(in_ch.read_index);

  cdb_ram #(
    .Width (CHAR_W),
    .Depth (Cells)
  ) u_cells (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wa),
    .wr_data (ram_wd),
    .rd_addr (ridx_addr),
    .rd_data (ram_rd)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (cmd)
            CMD_CLEAR, CMD_CLEAR_EOL: state_nxt = S_SWEEP;
            CMD_READ_CELL:            state_nxt = S_READ;
            default:                  state_nxt = S_RESULT;
          endcase
        end
      end
      S_SWEEP: begin
        if (sweep_addr_r == sweep_last_r) state_nxt = S_RESULT;
      end
      S_READ:   state_nxt = S_RESULT;
      S_RESULT: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ch.ready = 1'b0;
    ram_we      = 1'b0;
    ram_wa      = cur_addr;
    ram_wd      = in_ch.char_code;
    case (state_r)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        ram_we      = in_ch.valid && (cmd == CMD_WRITE);
      end
      S_SWEEP: begin
        ram_we = 1'b1;
        ram_wa = sweep_addr_r;
        ram_wd = SPACE_CHAR;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // cursor and result datapath
  always_comb begin
    cursor_col_nxt = cursor_col_r;
    cursor_row_nxt = cursor_row_r;
    sweep_addr_nxt = sweep_addr_r;
    sweep_last_nxt = sweep_last_r;
    rd_addr_nxt    = rd_addr_r;
    rd_ok_nxt      = rd_ok_r;
    cell_nxt       = cell_r;
    taken_nxt      = taken_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_col_nxt    = out_col_r;
    out_row_nxt    = out_row_r;
    out_cell_nxt   = out_cell_r;
    out_taken_nxt  = out_taken_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cell_nxt  = '0;
          taken_nxt = 1'b0;
          case (cmd)
            CMD_WRITE, CMD_RIGHT: begin
              if (cursor_col_r == CW'(Columns - 1) && !cursor_row_r) begin
                cursor_row_nxt = 1'b1;
                cursor_col_nxt = '0;
              end else if (cursor_col_r != CW'(Columns - 1)) begin
                cursor_col_nxt = cursor_col_r + CW'(1);
              end
            end
            CMD_LEFT: begin
              if (cursor_col_r == '0 && cursor_row_r) begin
                cursor_row_nxt = 1'b0;
                cursor_col_nxt = CW'(Columns - 1);
              end else if (cursor_col_r != '0) begin
                cursor_col_nxt = cursor_col_r - CW'(1);
              end
            end
            CMD_UP:   cursor_row_nxt = 1'b0;
            CMD_DOWN: cursor_row_nxt = 1'b1;
            CMD_CLEAR: begin
              sweep_addr_nxt = '0;
              sweep_last_nxt = AW'(Cells - 1);
              cursor_col_nxt = '0;
              cursor_row_nxt = 1'b0;
            end
            CMD_CLEAR_EOL: begin
              sweep_addr_nxt = cur_addr;
              sweep_last_nxt = row_end;
            end
            CMD_SET_CURSOR: begin
              if (int'(in_ch.target_column) < Columns && int'(in_ch.target_row) < ROWS) begin
                cursor_col_nxt = CW'(in_ch.target_column);
                cursor_row_nxt = in_ch.target_row[0];
                taken_nxt      = 1'b1;
              end
            end
            CMD_READ_CELL: begin
              rd_addr_nxt = ridx_addr;
              rd_ok_nxt   = int'(in_ch.read_index) < Cells;
            end
            default: begin
              cell_nxt = '0;
            end
          endcase
        end
      end
      S_SWEEP: begin
        sweep_addr_nxt = sweep_addr_r + AW'(1);
      end
      S_READ: begin
        // cells never written since reset read as spaces
        if (!rd_ok_r) cell_nxt = '0;
        else if (vld_r[rd_addr_r]) cell_nxt = ram_rd;
        else cell_nxt = SPACE_CHAR;
      end
      S_RESULT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_col_nxt   = OUT_COL_W'(cursor_col_r);
          out_row_nxt   = cursor_row_r;
          out_cell_nxt  = cell_r;
          out_taken_nxt = taken_r;
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cursor_col_r <= '0;
      cursor_row_r <= 1'b0;
      out_valid_r  <= 1'b0;
      vld_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      cursor_col_r <= cursor_col_nxt;
      cursor_row_r <= cursor_row_nxt;
      out_valid_r  <= out_valid_nxt;
      if (ram_we) vld_r[ram_wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    sweep_addr_r <= sweep_addr_nxt;
    sweep_last_r <= sweep_last_nxt;
    rd_addr_r    <= rd_addr_nxt;
    rd_ok_r      <= rd_ok_nxt;
    cell_r       <= cell_nxt;
    taken_r      <= taken_nxt;
    out_col_r    <= out_col_nxt;
    out_row_r    <= out_row_nxt;
    out_cell_r   <= out_cell_nxt;
    out_taken_r  <= out_taken_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.cursor_column  = out_col_r;
  assign out_ch.cursor_row     = out_row_r;
  assign out_ch.cell_char      = out_cell_r;
  assign out_ch.position_taken = out_taken_r;

  a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_col_r <= CW'(Columns - 1))
    else $error("cursor column past last column");

  a_sweep_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SWEEP |-> sweep_addr_r <= sweep_last_r)
    else $error("clear sweep ran past its last cell");

  a_result_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_RESULT))
    else $error("result appeared without sequencer result step");

  a_clear_homes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && cmd == CMD_CLEAR) |=>
      (cursor_col_r == '0 && !cursor_row_r && sweep_addr_r == '0 && state_r == S_SWEEP))
    else $error("clear did not home cursor and start sweep at cell zero");

  a_short_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && cmd != CMD_CLEAR && cmd != CMD_CLEAR_EOL && cmd != CMD_READ_CELL) |=>
      state_r == S_RESULT)
    else $error("single-step command did not go straight to result");

endmodule

`default_nettype wire
